// ===== src/keyframe_catmull_rom_interpolator_unit_defines.svh =====
// Assertion macros used by the interpolator back end.
`ifndef KEYFRAME_CATMULL_ROM_INTERPOLATOR_UNIT_DEFINES_SVH
`define KEYFRAME_CATMULL_ROM_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define KCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define KCR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/kcr_pkg.sv =====
// Types and constants of the keyframe Catmull-Rom interpolator.
package kcr_pkg;

    localparam logic MODE_LOAD = 1'b0;

    localparam logic [0:0] CFG_PERIOD = 1'b0;
    localparam logic [0:0] CFG_FRAMES = 1'b1;

    localparam int QUO_W        = 48;
    localparam int DIV_BITS     = 4;
    localparam int DIV_STEPS    = QUO_W / DIV_BITS;
    localparam int ACC_W        = 67;
    localparam int MAC_TERMS    = 12;

    typedef enum logic {
        K_LOAD = 1'b0,
        K_EVAL = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        node_ok;
        logic [3:0]  frame;
        logic [9:0]  node;
        logic [31:0] time_value;
        logic [95:0] pos;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_W1,
        ST_W2,
        ST_W3,
        ST_W4,
        ST_RD,
        ST_DIFF,
        ST_MAC,
        ST_FIN,
        ST_END
    } t_state;

endpackage

// ===== src/kcr_front.sv =====
// Front end: accepts transactions, classifies them and queues them for the back end.
module kcr_front
    import kcr_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int MAX_NODES  = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_mode,
    input  logic [3:0]  i_frame_index,
    input  logic [9:0]  i_node_index,
    input  logic [31:0] i_time_value,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic        i_pop,
    output t_item       o_item,
    output logic        o_item_valid
);

    t_item      item_in;
    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       accept, keep, frame_ok, node_ok;

    assign o_busy   = (r_cnt == 2'd2);
    assign accept   = i_start && !o_busy;
    assign frame_ok = 32'(i_frame_index) < 32'(MAX_FRAMES);
    assign node_ok  = 32'(i_node_index) < 32'(MAX_NODES);

    always_comb begin
        item_in.kind       = (i_mode == MODE_LOAD) ? K_LOAD : K_EVAL;
        item_in.node_ok    = node_ok;
        item_in.frame      = i_frame_index;
        item_in.node       = i_node_index;
        item_in.time_value = i_time_value;
        item_in.pos        = {i_pos_z, i_pos_y, i_pos_x};
    end

    // out-of-range loads are dropped here
    assign keep = accept && ((item_in.kind == K_EVAL) || (frame_ok && node_ok));

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_q[r_wp] <= item_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (keep) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({keep, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_item       = r_q[r_rp];
    assign o_item_valid = (r_cnt != 2'd0);

endmodule

// ===== src/kcr_back.sv =====
// Back end: keyframe memory, period divider, Hermite weights and shared MAC.
`include "keyframe_catmull_rom_interpolator_unit_defines.svh"
module kcr_back
    import kcr_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int MAX_NODES  = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_item                              i_item,
    input  logic                               i_item_valid,
    output logic                               o_pop,
    input  logic [23:0]                        i_period,
    input  logic [$clog2(MAX_FRAMES+1)-1:0]    i_frames,
    output logic                               o_valid,
    output logic [31:0]                        o_out_x,
    output logic [31:0]                        o_out_y,
    output logic [31:0]                        o_out_z,
    output logic [3:0]                         o_segment_number,
    output logic                               o_past_end
);

    localparam int DEPTH = MAX_FRAMES * MAX_NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(MAX_FRAMES);
    localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);
    localparam logic [3:0] MAC_LAST = 4'(MAC_TERMS);
    localparam logic signed [49:0] ONE48 = 50'sh1_0000_0000_0000;
    localparam logic signed [ACC_W-1:0] RND31  = 67'sd1073741824;
    localparam logic signed [ACC_W-1:0] SAT_HI = 67'sd2147483647;
    localparam logic signed [ACC_W-1:0] SAT_LO = -67'sd2147483648;

    function automatic logic [30:0] rnd_q30(input logic signed [49:0] h);
        logic signed [49:0] t;
        t = h + 50'sd131072;
        return t[48:18];
    endfunction

    t_state r_state, n_state;
    t_item  r_it;

    // divider
    logic [47:0] r_dvd, n_dvd, r_quo, n_quo;
    logic [23:0] r_rem, n_rem;
    logic [24:0] div_t;
    logic [3:0]  r_dc;
    logic [31:0] seg;
    logic [FW-1:0] seg_i;
    logic [15:0] frac;
    logic        past, use_d1, use_d2;

    // weights
    logic [31:0] r_s2;
    logic [47:0] r_s3;
    logic signed [49:0] s2q, s3q, s32;
    logic signed [49:0] r_h00r, r_h10r, r_gr;
    logic [30:0] r_h00, r_h01, r_h10, r_g;

    // keyframe memory
    logic [95:0]   r_mem [DEPTH];
    logic [95:0]   r_rdata;
    logic [95:0]   r_pr [4];
    logic [2:0]    r_rc;
    logic [31:0]   rd_frame, node_sel;
    logic [AW-1:0] rd_addr, wr_addr;

    // MAC
    logic signed [31:0] r_p1 [3];
    logic signed [31:0] r_p2 [3];
    logic signed [32:0] r_d1 [3];
    logic signed [32:0] r_d2 [3];
    logic [3:0]         r_mc;
    logic [1:0]         mc_ax, mc_t, r_pt, r_pax;
    logic signed [32:0] mac_a;
    logic signed [31:0] mac_w;
    logic signed [64:0] r_prod;
    logic               r_pv;
    logic signed [ACC_W-1:0] r_acc [3];
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] fin_t [3];
    logic [31:0]        fin_o [3];

    logic        r_valid, r_past;
    logic [31:0] r_out_x, r_out_y, r_out_z;
    logic [3:0]  r_seg_o;

    assign o_pop  = (r_state == ST_IDLE) && i_item_valid;
    assign seg    = r_quo[47:16];
    assign frac   = r_quo[15:0];
    assign seg_i  = r_quo[16 +: FW];
    assign past   = seg >= (32'(i_frames) - 32'd1);
    assign use_d1 = (seg_i != '0);
    assign use_d2 = (32'(seg_i) + 32'd2) < 32'(i_frames);

    // radix-16 restoring division of {time, 16'b0} by the period
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        n_quo = r_quo;
        div_t = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            div_t = {n_rem, n_dvd[47]};
            n_dvd = {n_dvd[46:0], 1'b0};
            if (div_t >= {1'b0, i_period}) begin
                n_rem = 24'(div_t - {1'b0, i_period});
                n_quo = {n_quo[46:0], 1'b1};
            end else begin
                n_rem = div_t[23:0];
                n_quo = {n_quo[46:0], 1'b0};
            end
        end
    end

    assign s2q = $signed({2'b00, r_s2, 16'b0});
    assign s3q = $signed({2'b00, r_s3});
    assign s32 = $signed({2'b00, frac, 32'b0});

    assign wr_addr  = AW'(32'(i_item.frame) * 32'(MAX_NODES) + 32'(i_item.node));
    assign rd_frame = 32'(seg_i) + 32'(r_rc) - 32'd1;
    assign node_sel = r_it.node_ok ? 32'(r_it.node) : 32'd0;
    assign rd_addr  = AW'(((rd_frame < 32'(MAX_FRAMES)) ? rd_frame : 32'd0)
                          * 32'(MAX_NODES) + node_sel);

    assign mc_ax = r_mc[3:2];
    assign mc_t  = r_mc[1:0];

    always_comb begin
        unique case (mc_t)
            2'd0: begin
                mac_a = {r_p1[mc_ax], 1'b0};
                mac_w = $signed({1'b0, r_h00});
            end
            2'd1: begin
                mac_a = {r_p2[mc_ax], 1'b0};
                mac_w = $signed({1'b0, r_h01});
            end
            2'd2: begin
                mac_a = r_d1[mc_ax];
                mac_w = $signed({1'b0, r_h10});
            end
            default: begin
                mac_a = r_d2[mc_ax];
                mac_w = $signed({1'b0, r_g});
            end
        endcase
    end

    assign acc_base = (r_pt == 2'd0) ? '0 : r_acc[r_pax];

    // round half up to Q16.16 and saturate
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            fin_t[a] = (r_acc[a] + RND31) >>> 31;
            if (fin_t[a] > SAT_HI) begin
                fin_o[a] = 32'h7FFF_FFFF;
            end else if (fin_t[a] < SAT_LO) begin
                fin_o[a] = 32'h8000_0000;
            end else begin
                fin_o[a] = fin_t[a][31:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid && (i_item.kind == K_EVAL)) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_dc == DIV_LAST) begin
                    n_state = ST_W1;
                end
            end
            ST_W1:   n_state = past ? ST_END : ST_W2;
            ST_W2:   n_state = ST_W3;
            ST_W3:   n_state = ST_W4;
            ST_W4:   n_state = ST_RD;
            ST_RD: begin
                if (r_rc == 3'd4) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: n_state = ST_MAC;
            ST_MAC: begin
                if (r_mc == MAC_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:  n_state = ST_IDLE;
            ST_END:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_FIN) || (r_state == ST_END);
            r_pv    <= (r_state == ST_MAC) && (r_mc < MAC_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_item.kind == K_LOAD)) begin
            r_mem[wr_addr] <= i_item.pos;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_acc[r_pax] <= (r_pt == 2'd3) ? acc_base - ACC_W'(r_prod)
                                            : acc_base + ACC_W'(r_prod);
        end
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_it  <= i_item;
                    r_dvd <= {i_item.time_value, 16'b0};
                    r_rem <= '0;
                    r_quo <= '0;
                    r_dc  <= '0;
                end
            end
            ST_DIV: begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_dc  <= r_dc + 4'd1;
            end
            ST_W1: begin
                r_s2    <= 32'(frac) * 32'(frac);
                r_seg_o <= (seg > 32'd15) ? 4'd15 : seg[3:0];
                r_rc    <= '0;
            end
            ST_W2: begin
                r_s3 <= 48'(r_s2) * 48'(frac);
            end
            ST_W3: begin
                r_h00r <= ONE48 - s2q - (s2q <<< 1) + (s3q <<< 1);
                r_h10r <= s3q - (s2q <<< 1) + s32;
                r_gr   <= s2q - s3q;
            end
            ST_W4: begin
                r_h00 <= rnd_q30(r_h00r);
                r_h01 <= rnd_q30(ONE48 - r_h00r);
                r_h10 <= rnd_q30(r_h10r);
                r_g   <= rnd_q30(r_gr);
            end
            ST_RD: begin
                r_rc <= r_rc + 3'd1;
                if (r_rc != 3'd0) begin
                    r_pr[2'(r_rc - 3'd1)] <= r_it.node_ok ? r_rdata : '0;
                end
            end
            ST_DIFF: begin
                for (int a = 0; a < 3; a++) begin
                    r_p1[a] <= $signed(r_pr[1][32*a +: 32]);
                    r_p2[a] <= $signed(r_pr[2][32*a +: 32]);
                    r_d1[a] <= use_d1 ? 33'($signed(r_pr[2][32*a +: 32]))
                                        - 33'($signed(r_pr[0][32*a +: 32])) : '0;
                    r_d2[a] <= use_d2 ? 33'($signed(r_pr[3][32*a +: 32]))
                                        - 33'($signed(r_pr[1][32*a +: 32])) : '0;
                end
                r_mc <= '0;
            end
            ST_MAC: begin
                if (r_mc < MAC_LAST) begin
                    r_prod <= mac_a * mac_w;
                    r_pt   <= mc_t;
                    r_pax  <= mc_ax;
                    r_mc   <= r_mc + 4'd1;
                end
            end
            ST_FIN: begin
                r_out_x <= fin_o[0];
                r_out_y <= fin_o[1];
                r_out_z <= fin_o[2];
                r_past  <= 1'b0;
            end
            ST_END: begin
                r_out_x <= '0;
                r_out_y <= '0;
                r_out_z <= '0;
                r_past  <= 1'b1;
            end
            default: begin
                r_past <= r_past;
            end
        endcase
    end

    assign o_valid          = r_valid;
    assign o_out_x          = r_out_x;
    assign o_out_y          = r_out_y;
    assign o_out_z          = r_out_z;
    assign o_segment_number = r_seg_o;
    assign o_past_end       = r_past;

    `KCR_ASSERT_IMP(a_valid_src, r_valid,
        ($past(r_state) == ST_FIN) || ($past(r_state) == ST_END),
        "result strobe without a finishing state")
    `KCR_ASSERT_NXT(a_strobe_once, r_valid, !r_valid, "result strobe longer than one cycle")
    `KCR_ASSERT_IMP(a_past_zero, r_valid && r_past,
        (r_out_x == 32'd0) && (r_out_y == 32'd0) && (r_out_z == 32'd0),
        "past-end result with nonzero coordinates")

endmodule

// ===== src/keyframe_catmull_rom_interpolator_unit.sv =====
// Top level of the keyframe Catmull-Rom interpolator.
// A load transaction (mode 0) writes one node's x/y/z keyframe into the keyframe
// memory; an evaluate transaction (mode 1) returns one interpolated position on
// o_valid, held for a single cycle - the receiver cannot stall, so it must take
// every strobe. Transactions enter on start while busy is low and wait in a
// two-entry queue, so the front keeps accepting while the back end works.
// Per item the back end: for a load, writes the keyframe as it is dequeued; for an
// evaluate, dequeues it, runs the shared divider retiring 4 quotient bits per cycle
// over the 48-bit time/period quotient, computes the Hermite weights, makes the four
// keyframe reads through the memory's single read port, forms the neighbor
// differences and runs 12 products through the one shared multiplier, then rounds;
// an evaluate at or past the last frame goes from the divider to its result. The result
// strobe comes in the cycle after the last of those. The keyframe memory has no reset
// and is never cleared: evaluate only frames that were loaded for that node.
// Configuration (index 0 segment_period, index 1 frame_count) is taken at any
// cycle; change it only while no evaluate is in flight.
module keyframe_catmull_rom_interpolator_unit
    import kcr_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int MAX_NODES  = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item transaction
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [3:0]  i_frame_index,
    input  logic [9:0]  i_node_index,
    input  logic [31:0] i_time_value,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    // result strobe
    output logic        o_valid,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    output logic [3:0]  o_segment_number,
    output logic        o_past_end
);

    localparam int FCW = $clog2(MAX_FRAMES + 1);

    logic [23:0]    r_period;
    logic [4:0]     r_frames;
    logic [23:0]    period_eff;
    logic [FCW-1:0] frames_eff;
    t_item          q_item;
    logic           q_valid, q_pop;

    // Config port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 24'd1024;
            r_frames <= 5'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PERIOD: r_period <= i_cfg_data;
                CFG_FRAMES: r_frames <= i_cfg_data[4:0];
            endcase
        end
    end

    // A zero period behaves as one; frame count is clamped to [2, MAX_FRAMES].
    assign period_eff = (r_period == 24'd0) ? 24'd1 : r_period;

    always_comb begin
        if (r_frames < 5'd2) begin
            frames_eff = FCW'(2);
        end else if (32'(r_frames) > 32'(MAX_FRAMES)) begin
            frames_eff = FCW'(MAX_FRAMES);
        end else begin
            frames_eff = FCW'(r_frames);
        end
    end

    kcr_front #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_NODES  (MAX_NODES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_mode        (i_mode),
        .i_frame_index (i_frame_index),
        .i_node_index  (i_node_index),
        .i_time_value  (i_time_value),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_pop         (q_pop),
        .o_item        (q_item),
        .o_item_valid  (q_valid)
    );

    kcr_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_NODES  (MAX_NODES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (q_item),
        .i_item_valid     (q_valid),
        .o_pop            (q_pop),
        .i_period         (period_eff),
        .i_frames         (frames_eff),
        .o_valid          (o_valid),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_out_z          (o_out_z),
        .o_segment_number (o_segment_number),
        .o_past_end       (o_past_end)
    );

endmodule

// ===== bench/tb_keyframe_catmull_rom_interpolator_unit.sv =====
// Self-checking bench for the keyframe Catmull-Rom interpolator: random loads/evaluates vs. a predictor.
module tb_keyframe_catmull_rom_interpolator_unit;
    import kcr_pkg::*;

    localparam int NFRAMES   = 16;
    localparam int NNODES    = 1024;
    localparam int WD_LIMIT  = 3000;
    localparam int DRAIN_CYC = 80;

    typedef struct {
        logic        mode;
        logic [3:0]  frame;
        logic [9:0]  node;
        logic [31:0] tval;
        logic [31:0] px, py, pz;
    } item_t;

    typedef struct {
        logic [31:0] x, y, z;
        logic [3:0]  seg;
        logic        past;
    } point_t;

    // Scoreboard: carries its own copy of the keyframe memory and registers.
    class spline_scoreboard;
        logic [95:0]  keyframes [NFRAMES*NNODES];
        logic [23:0]  period;
        logic [4:0]   frames;
        point_t       pending [$];
        int           mismatches;

        function new();
            period     = 24'd1024;
            frames     = 5'd2;
            mismatches = 0;
            foreach (keyframes[k]) keyframes[k] = '0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [23:0] data);
            if (idx == CFG_PERIOD) period = data;
            else                   frames = data[4:0];
        endfunction

        function automatic logic signed [95:0] coord(int fr, logic [9:0] node, int axis);
            logic [95:0] e;
            e = keyframes[fr*NNODES + node];
            return $signed(e[32*axis +: 32]);
        endfunction

        function automatic longint q30(longint v);
            return (v + (longint'(1) <<< 17)) >>> 18;
        endfunction

        // Accepted transaction: a load updates memory, an evaluate queues a point.
        function void note_item(item_t it);
            longint unsigned per, seg, rem, fc, sq;
            longint          s2, s3, h00, h01, h10, g;
            logic signed [95:0] p0, p1, p2, p3, d1, d2, acc, q;
            logic [31:0] res [3];
            point_t      pt;
            if (it.mode == MODE_LOAD) begin
                keyframes[it.frame*NNODES + it.node] = {it.pz, it.py, it.px};
                return;
            end
            per = (period == 0) ? 1 : period;
            fc  = frames;
            if (fc < 2) fc = 2;
            if (fc > NFRAMES) fc = NFRAMES;
            seg = it.tval / per;
            rem = it.tval % per;
            pt.seg = (seg > 15) ? 4'd15 : seg[3:0];
            if (seg >= fc - 1) begin
                pt.x = '0; pt.y = '0; pt.z = '0; pt.past = 1'b1;
                pending.push_back(pt);
                return;
            end
            pt.past = 1'b0;
            sq  = (rem << 16) / per;
            s2  = longint'((sq * sq) << 16);
            s3  = longint'(sq * sq * sq);
            h00 = (longint'(1) <<< 48) - 3 * s2 + 2 * s3;
            h01 = (longint'(1) <<< 48) - h00;
            h10 = s3 - 2 * s2 + longint'(sq << 32);
            g   = s2 - s3;
            h00 = q30(h00); h01 = q30(h01); h10 = q30(h10); g = q30(g);
            for (int a = 0; a < 3; a++) begin
                p1 = coord(int'(seg), it.node, a);
                p2 = coord(int'(seg) + 1, it.node, a);
                d1 = '0;
                d2 = '0;
                if (seg > 0) begin
                    p0 = coord(int'(seg) - 1, it.node, a);
                    d1 = p2 - p0;
                end
                if (seg + 2 < fc) begin
                    p3 = coord(int'(seg) + 2, it.node, a);
                    d2 = p3 - p1;
                end
                acc = 96'sd2 * p1 * h00 + 96'sd2 * p2 * h01 + d1 * h10 - d2 * g;
                q   = (acc + (96'sd1 <<< 30)) >>> 31;
                if (q > 96'sd2147483647)       q = 96'sd2147483647;
                else if (q < -96'sd2147483648) q = -96'sd2147483648;
                res[a] = q[31:0];
            end
            pt.x = res[0]; pt.y = res[1]; pt.z = res[2];
            pending.push_back(pt);
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result x=%h y=%h z=%h seg=%0d past=%b",
                             got.x, got.y, got.z, got.seg, got.past);
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.seg !== want.seg || got.past !== want.past) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp x=%h y=%h z=%h seg=%0d past=%b, got x=%h y=%h z=%h seg=%0d past=%b",
                             want.x, want.y, want.z, want.seg, want.past,
                             got.x, got.y, got.z, got.seg, got.past);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_mode;
    logic [3:0]  i_frame_index;
    logic [9:0]  i_node_index;
    logic [31:0] i_time_value, i_pos_x, i_pos_y, i_pos_z;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        o_valid;
    logic [31:0] o_out_x, o_out_y, o_out_z;
    logic [3:0]  o_segment_number;
    logic        o_past_end;

    keyframe_catmull_rom_interpolator_unit DUT (.*);

    spline_scoreboard sb = new();
    logic [15:0] loaded_mask [NNODES];
    int          node_pool [$];
    int          idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                point_t got;
                got.x = o_out_x; got.y = o_out_y; got.z = o_out_z;
                got.seg = o_segment_number; got.past = o_past_end;
                sb.check_point(got);
            end
            if (o_valid || (start && !busy) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_item(item_t it);
        start         <= 1'b1;
        i_mode        <= it.mode;
        i_frame_index <= it.frame;
        i_node_index  <= it.node;
        i_time_value  <= it.tval;
        i_pos_x       <= it.px;
        i_pos_y       <= it.py;
        i_pos_z       <= it.pz;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        if (it.mode == MODE_LOAD) loaded_mask[it.node][it.frame] = 1'b1;
    endtask

    task automatic send_gap(item_t it);
        int gap;
        send_item(it);
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain before touching registers; loads leave no result to wait on.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [0:0] idx, logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t load_of(int fr, int node);
        item_t it;
        it.mode = MODE_LOAD;
        it.frame = 4'(fr);
        it.node = 10'(node);
        it.tval = $urandom;
        it.px = rand_pos(); it.py = rand_pos(); it.pz = rand_pos();
        return it;
    endfunction

    // Evaluate: mostly aimed inside the loaded segments, some past the end or fully random.
    function automatic item_t eval_of();
        item_t           it;
        longint unsigned per, fc, seg, rem;
        int              node;
        per = (sb.period == 0) ? 1 : sb.period;
        fc  = (sb.frames < 2) ? 2 : (sb.frames > NFRAMES) ? NFRAMES : sb.frames;
        it.mode = ~MODE_LOAD;
        it.frame = 4'($urandom);
        it.px = $urandom; it.py = $urandom; it.pz = $urandom;
        case ($urandom_range(0, 9))
            0:  seg = $urandom_range(fc - 1, 17);
            1:  seg = fc - 2;
            default: seg = $urandom_range(0, fc - 2);
        endcase
        case ($urandom_range(0, 5))
            0:       rem = 0;
            1:       rem = per - 1;
            default: rem = $urandom_range(0, per - 1);
        endcase
        it.tval = 32'(seg * per + rem);
        if ($urandom_range(0, 15) == 0) it.tval = $urandom;
        // Any node is safe past the end; inside the span only fully loaded nodes.
        if (it.tval / per >= fc - 1) begin
            it.node = 10'($urandom);
        end else begin
            node = $urandom_range(0, NNODES - 1);
            if (loaded_mask[node] != 16'hFFFF)
                node = node_pool[$urandom_range(0, node_pool.size() - 1)];
            it.node = 10'(node);
        end
        return it;
    endfunction

    task automatic random_phase(int count);
        item_t it;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 2) == 0)
                it = load_of($urandom_range(0, NFRAMES - 1),
                             ($urandom_range(0, 1) == 0) ?
                             node_pool[$urandom_range(0, node_pool.size() - 1)] :
                             $urandom_range(0, NNODES - 1));
            else
                it = eval_of();
            send_gap(it);
        end
    endtask

    initial begin
        item_t it;
        logic [23:0] per_set [8] = '{24'd1, 24'd0, 24'hFFFFFF, 24'd7, 24'd1000,
                                     24'd65536, 24'd3, 24'd123457};
        logic [23:0] frm_set [8] = '{24'd16, 24'd5, 24'd16, 24'd1, 24'd31,
                                     24'hFFFFFF, 24'd3, 24'd0};
        idle_cycles   = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_mode        = 1'b0;
        i_frame_index = '0;
        i_node_index  = '0;
        i_time_value  = '0;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_pos_z       = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        foreach (loaded_mask[k]) loaded_mask[k] = '0;
        node_pool = '{0, 1023, 341, 682};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every frame of the pool nodes; extreme coordinates on node 0.
        foreach (node_pool[k])
            for (int f = 0; f < NFRAMES; f++) begin
                it = load_of(f, node_pool[k]);
                if (k == 0) begin
                    it.px = (f % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    it.py = (f % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    it.pz = '0;
                end
                send_gap(it);
            end

        // Directed evaluates under reset registers: edges of time and past end.
        it = eval_of();
        it.node = 0;
        foreach (frm_set[k]) begin
            it.tval = (k == 0) ? 32'd0 : (k == 1) ? 32'd1023 : (k == 2) ? 32'd512 :
                      (k == 3) ? 32'd1024 : (k == 4) ? 32'hFFFF_FFFF : 32'd5000 + k;
            send_gap(it);
        end
        random_phase(150);

        foreach (per_set[k]) begin
            drain();
            cfg_write(CFG_PERIOD, per_set[k]);
            cfg_write(CFG_FRAMES, frm_set[k]);
            if (k == 2) begin
                // Longest span with the widest period: corners of the time range.
                it = eval_of();
                it.node = 1023;
                it.tval = 32'd0;           send_gap(it);
                it.tval = 32'hFFFF_FFFF;   send_gap(it);
                it.tval = 32'h0EFF_FFFF;   send_gap(it);
                it.tval = 32'h0DFF_FFFF;   send_gap(it);
            end
            random_phase(190);
        end

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
